/* sv/rrtt_pkg.sv */
package rrtt_pkg;

    localparam logic [1:0] OP_ARM      = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SEND    = 2'd1;
    localparam logic [1:0] EV_OK      = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_CMD_ONLY = 3'd4;

    localparam logic [7:0] CMD_ONLY_ADDR = 8'hFF;
    localparam logic [7:0] SENDS_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] address;
        logic       active;
        logic       wait_mode;
        logic [7:0] retries;
        logic [7:0] sends;
        logic       payload_flag;
        logic       notify_flag;
    } entry_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] entry;
        logic       run_payload;
        logic       notify;
    } result_t;

endpackage

/* sv/rrtt_ram.sv */
module rrtt_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/request_retry_timeout_table.sv */
// arm, undefined operations and responses with an invalid frame kind give their
// single result in the cycle after an accepted start; a response or tick walks the
// entries through the table memory, one entry a cycle, until a match, a send or the
// last entry, then closes the item in a flush state that gives its last result.
// throughput: an arm every cycle; no new start is taken while a walk is busy; the receiver cannot stall.
// reset (async, active low) clears every entry at once through per-entry valid bits.
module request_retry_timeout_table #(
    parameter int ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [3:0] slot,
    input  logic [7:0] command,
    input  logic [7:0] target_address,
    input  logic [7:0] retry_budget,
    input  logic       wait_response,
    input  logic       has_payload_handler,
    input  logic       has_notify_handler,
    input  logic [2:0] frame_kind,
    output logic       result_strobe,
    output logic [1:0] event_res,
    output logic [3:0] entry,
    output logic       run_payload,
    output logic       notify,
    output logic       last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    rrtt_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic              pend_valid_reg, pend_valid_next;
    rrtt_pkg::result_t pend_reg, pend_next;
    logic              strobe_reg, strobe_next;
    rrtt_pkg::result_t res_reg, res_next;
    logic              last_reg, last_next;
    logic [ENTRIES-1:0] valid_reg;

    logic [1:0]        op_reg;
    logic [7:0]        cmd_reg;
    logic [7:0]        addr_reg;
    logic              cmd_only_reg;

    logic              accept;
    logic              slot_ok;
    logic              kind_ok;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    rrtt_pkg::entry_t  wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [$bits(rrtt_pkg::entry_t)-1:0] rdata;
    rrtt_pkg::entry_t  cur;
    rrtt_pkg::entry_t  retired;
    logic [7:0]        sends_bumped;
    logic              hit;
    logic              at_last;
    logic              have_new;
    rrtt_pkg::result_t new_res;
    logic              stop;

    assign busy    = (state_reg != rrtt_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(slot) < 32'(ENTRIES));
    assign kind_ok = (frame_kind != rrtt_pkg::KIND_NONE) && (frame_kind <= rrtt_pkg::KIND_CMD_ONLY);

    rrtt_ram #(
        .WIDTH ($bits(rrtt_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur = valid_reg[p_reg] ? rrtt_pkg::entry_t'(rdata) : '0;

    always_comb
    begin
        retired              = cur;
        retired.active       = 1'b0;
        retired.retries      = '0;
        retired.sends        = '0;
        retired.notify_flag  = 1'b0;
    end

    assign sends_bumped = (cur.sends == rrtt_pkg::SENDS_MAX) ? cur.sends : cur.sends + 8'd1;
    assign at_last      = (p_reg == LAST_IDX);

    always_comb
    begin
        if (cmd_only_reg)
        begin
            hit = (cur.address == rrtt_pkg::CMD_ONLY_ADDR) && (cur.command == cmd_reg);
        end
        else
        begin
            hit = (cur.command == cmd_reg) && (cur.address == addr_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        res_next        = '0;
        last_next       = 1'b0;
        we              = 1'b0;
        waddr           = p_reg;
        wdata           = cur;
        re              = 1'b0;
        raddr           = '0;
        have_new        = 1'b0;
        new_res         = '0;
        stop            = 1'b0;

        unique case (state_reg)
            rrtt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation) inside
                        rrtt_pkg::OP_ARM:
                        begin
                            if (slot_ok)
                            begin
                                we                 = 1'b1;
                                waddr              = IDX_W'(slot);
                                wdata.command      = command;
                                wdata.address      = target_address;
                                wdata.active       = 1'b1;
                                wdata.wait_mode    = wait_response;
                                wdata.retries      = retry_budget;
                                wdata.sends        = '0;
                                wdata.payload_flag = has_payload_handler;
                                wdata.notify_flag  = has_notify_handler;
                            end
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                        end
                        rrtt_pkg::OP_RESPONSE, rrtt_pkg::OP_TICK:
                        begin
                            if ((operation == rrtt_pkg::OP_TICK) || kind_ok)
                            begin
                                re              = 1'b1;
                                raddr           = '0;
                                p_next          = '0;
                                pend_valid_next = 1'b0;
                                state_next      = rrtt_pkg::ST_SCAN;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end

            rrtt_pkg::ST_SCAN:
            begin
                re     = !at_last;
                raddr  = p_reg + IDX_W'(1);
                p_next = p_reg + IDX_W'(1);
                if (op_reg == rrtt_pkg::OP_RESPONSE)
                begin
                    if (hit)
                    begin
                        stop = 1'b1;
                        if (cur.sends != '0)
                        begin
                            we                  = 1'b1;
                            wdata               = retired;
                            have_new            = 1'b1;
                            new_res.event_res   = rrtt_pkg::EV_OK;
                            new_res.entry       = 4'(p_reg);
                            new_res.run_payload = cur.payload_flag;
                            new_res.notify      = cur.notify_flag;
                        end
                    end
                end
                else if (cur.active)
                begin
                    if (!cur.wait_mode || (cur.retries != '0))
                    begin
                        we          = 1'b1;
                        wdata.sends = sends_bumped;
                        if (!cur.wait_mode)
                        begin
                            wdata.active = 1'b0;
                        end
                        else
                        begin
                            wdata.retries = cur.retries - 8'd1;
                        end
                        have_new          = 1'b1;
                        new_res.event_res = rrtt_pkg::EV_SEND;
                        new_res.entry     = 4'(p_reg);
                        stop              = 1'b1;
                    end
                    else
                    begin
                        we                = 1'b1;
                        wdata             = retired;
                        have_new          = 1'b1;
                        new_res.event_res = rrtt_pkg::EV_TIMEOUT;
                        new_res.entry     = 4'(p_reg);
                        new_res.notify    = cur.notify_flag;
                    end
                end
                if (at_last)
                begin
                    stop = 1'b1;
                end
                // hold back one result so the final one can carry last
                if (have_new)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next    = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = new_res;
                end
                if (stop)
                begin
                    state_next = rrtt_pkg::ST_FLUSH;
                end
            end

            rrtt_pkg::ST_FLUSH:
            begin
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                res_next        = pend_valid_reg ? pend_reg : '0;
                pend_valid_next = 1'b0;
                state_next      = rrtt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = rrtt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrtt_pkg::ST_IDLE;
            p_reg          <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
            res_reg        <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            p_reg          <= p_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
            res_reg        <= res_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            op_reg       <= operation;
            cmd_reg      <= command;
            addr_reg     <= target_address;
            cmd_only_reg <= (frame_kind == rrtt_pkg::KIND_CMD_ONLY);
        end
    end

    assign result_strobe = strobe_reg;
    assign event_res     = res_reg.event_res;
    assign entry         = res_reg.entry;
    assign run_payload   = res_reg.run_payload;
    assign notify        = res_reg.notify;
    assign last          = last_reg;

endmodule
